[design/irpd_pkg.sv]
// ----------------------------------------------------------------------------
// irpd_pkg
// Shared constants and types of the IR pulse-distance frame encoder.
// ----------------------------------------------------------------------------
package irpd_pkg;

    // Frame layout
    localparam int MAIN_BITS    = 28;
    localparam int EXT_BITS     = 32;
    localparam int SHORT_BITS   = 8;
    localparam int TRAILER_BITS = 8;
    localparam int GUARD_ZEROS  = 1;

    // Storage widths
    localparam int SLOT_W      = 6;
    localparam int BIT_IDX_W   = 6;
    localparam int SHIFT_W     = 32;
    localparam int SHIFT_IDX_W = $clog2(SHIFT_W);
    localparam int SEG_W       = 6;
    localparam int SPACE_W     = 3;
    localparam int TRAIL_W     = 8;
    localparam int TRAIL_IDX_W = $clog2(TRAIL_W);
    localparam int CMD_W       = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 8;

    // Register reset values
    localparam logic [SEG_W-1:0]   RST_START_MARK        = 6'd16;
    localparam logic [SEG_W-1:0]   RST_START_SPACE       = 6'd8;
    localparam logic [SEG_W-1:0]   RST_SHORT_START_MARK  = 6'd10;
    localparam logic [SEG_W-1:0]   RST_SHORT_START_SPACE = 6'd5;
    localparam logic [SEG_W-1:0]   RST_GAP               = 6'd34;
    localparam logic [SPACE_W-1:0] RST_ONE_SPACE         = 3'd3;
    localparam logic [SPACE_W-1:0] RST_ZERO_SPACE        = 3'd1;
    localparam logic [TRAIL_W-1:0] RST_TRAILER           = 8'd165;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_LONG  = 2'd1,
        CMD_SHORT = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_SMARK  = 3'd1,
        PH_SSPACE = 3'd2,
        PH_DATA   = 3'd3,
        PH_TRAIL  = 3'd4,
        PH_GAP    = 3'd5,
        PH_EXT    = 3'd6,
        PH_GUARD  = 3'd7
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_MARK        = 3'd0,
        REG_START_SPACE       = 3'd1,
        REG_SHORT_START_MARK  = 3'd2,
        REG_SHORT_START_SPACE = 3'd3,
        REG_GAP               = 3'd4,
        REG_ONE_SPACE         = 3'd5,
        REG_ZERO_SPACE        = 3'd6,
        REG_TRAILER           = 3'd7
    } t_cfg_idx;

endpackage

[design/irpd_if.sv]
// ----------------------------------------------------------------------------
// irpd interfaces
// Command, slot result and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface irpd_in_if;
    import irpd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CMD_W-1:0]      cmd;
    logic [MAIN_BITS-1:0]  main_word;
    logic [EXT_BITS-1:0]   ext_word;
    logic [SHORT_BITS-1:0] short_word;

    modport source (output valid, cmd, main_word, ext_word, short_word, input ready);
    modport sink   (input valid, cmd, main_word, ext_word, short_word, output ready);
endinterface

interface irpd_out_if;
    logic valid;
    logic ready;
    logic carrier_on;
    logic busy_res;
    logic last;

    modport source (output valid, carrier_on, busy_res, last, input ready);
    modport sink   (input valid, carrier_on, busy_res, last, output ready);
endinterface

interface irpd_cfg_if;
    import irpd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] wdata;

    modport source (output valid, idx, wdata, input ready);
    modport sink   (input valid, idx, wdata, output ready);
endinterface

[design/ir_pulse_distance_frame_encoder_unit.sv]
// ----------------------------------------------------------------------------
// ir_pulse_distance_frame_encoder_unit
// Slot-level IR frame encoder: a send command loads a frame, each tick
// transfer returns the carrier level of the next symbol slot.
// ----------------------------------------------------------------------------
// A tick transfer writes its result into the output register. Throughput: one
// command per cycle; input stalls only while a result waits in the output
// register and the sink is not ready. A send command gives no result. Reset
// (synchronous, active low) loads the register defaults, puts the encoder idle
// and empties the output register.
module ir_pulse_distance_frame_encoder_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    irpd_in_if.sink            i_in,
    irpd_out_if.source         o_out,
    irpd_cfg_if.sink           i_cfg
);
    import irpd_pkg::*;

    // Configuration registers
    logic [SEG_W-1:0]   r_start_mark, r_start_space;
    logic [SEG_W-1:0]   r_short_start_mark, r_short_start_space, r_gap;
    logic [SPACE_W-1:0] r_one_space, r_zero_space;
    logic [TRAIL_W-1:0] r_trailer;

    // Frame state
    t_phase               r_phase, n_phase;
    logic [SLOT_W-1:0]    r_slot, n_slot;
    logic [BIT_IDX_W-1:0] r_bit, n_bit;
    logic [SHIFT_W-1:0]   r_data, n_data;
    logic [SHIFT_W-1:0]   r_ext, n_ext;
    logic                 r_short, n_short;

    // Result register
    logic r_out_valid, n_out_valid;
    logic r_carrier, n_carrier;
    logic r_busy, n_busy;
    logic r_last, n_last;

    logic                 in_acc;
    logic                 is_tick;
    logic                 cur_bit;
    logic                 level;
    logic                 adv;
    logic [SEG_W-1:0]     unit_len;
    logic [BIT_IDX_W-1:0] units;
    logic [SLOT_W-1:0]    slot_inc;
    logic [BIT_IDX_W-1:0] bit_inc;
    t_phase               succ;

    // Resolve the phase to enter: skip empty segments and empty phases.
    function automatic t_phase f_enter(
        input t_phase ph,
        input logic   sm,
        input logic   smark_zero,
        input logic   sspace_zero,
        input logic   gap_zero
    );
        t_phase p;
        p = ph;
        if (p == PH_SMARK && smark_zero) begin
            p = PH_SSPACE;
        end
        if (p == PH_SSPACE && sspace_zero) begin
            p = PH_DATA;
        end
        if (p == PH_GAP && (sm || gap_zero)) begin
            p = PH_EXT;
        end
        if (p == PH_EXT && sm) begin
            p = PH_GUARD;
        end
        if (p == PH_GUARD && GUARD_ZEROS == 0) begin
            p = PH_IDLE;
        end
        return p;
    endfunction

    assign in_acc      = i_in.valid && i_in.ready;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid      = r_out_valid;
    assign o_out.carrier_on = r_carrier;
    assign o_out.busy_res   = r_busy;
    assign o_out.last       = r_last;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_mark        <= RST_START_MARK;
            r_start_space       <= RST_START_SPACE;
            r_short_start_mark  <= RST_SHORT_START_MARK;
            r_short_start_space <= RST_SHORT_START_SPACE;
            r_gap               <= RST_GAP;
            r_one_space         <= RST_ONE_SPACE;
            r_zero_space        <= RST_ZERO_SPACE;
            r_trailer           <= RST_TRAILER;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (t_cfg_idx'(i_cfg.idx))
                REG_START_MARK:        r_start_mark        <= i_cfg.wdata[SEG_W-1:0];
                REG_START_SPACE:       r_start_space       <= i_cfg.wdata[SEG_W-1:0];
                REG_SHORT_START_MARK:  r_short_start_mark  <= i_cfg.wdata[SEG_W-1:0];
                REG_SHORT_START_SPACE: r_short_start_space <= i_cfg.wdata[SEG_W-1:0];
                REG_GAP:               r_gap               <= i_cfg.wdata[SEG_W-1:0];
                REG_ONE_SPACE:         r_one_space         <= i_cfg.wdata[SPACE_W-1:0];
                REG_ZERO_SPACE:        r_zero_space        <= i_cfg.wdata[SPACE_W-1:0];
                REG_TRAILER:           r_trailer           <= i_cfg.wdata[TRAIL_W-1:0];
                default: ;
            endcase
        end
    end

    // Current slot decode
    always_comb begin
        unique case (r_phase)
            PH_DATA:  cur_bit = r_data[r_bit[SHIFT_IDX_W-1:0]];
            PH_TRAIL: cur_bit = r_trailer[r_bit[TRAIL_IDX_W-1:0]];
            PH_EXT:   cur_bit = r_ext[r_bit[SHIFT_IDX_W-1:0]];
            default:  cur_bit = 1'b0;
        endcase

        unique case (r_phase)
            PH_SMARK:  unit_len = r_short ? r_short_start_mark : r_start_mark;
            PH_SSPACE: unit_len = r_short ? r_short_start_space : r_start_space;
            PH_GAP:    unit_len = r_gap;
            PH_DATA, PH_TRAIL, PH_EXT, PH_GUARD:
                unit_len = SEG_W'(cur_bit ? r_one_space : r_zero_space) + SEG_W'(1);
            default:   unit_len = '0;
        endcase

        unique case (r_phase)
            PH_SMARK, PH_SSPACE: units = BIT_IDX_W'(1);
            PH_DATA:  units = r_short ? BIT_IDX_W'(SHORT_BITS) : BIT_IDX_W'(MAIN_BITS);
            PH_TRAIL: units = BIT_IDX_W'(TRAILER_BITS);
            PH_GAP:   units = r_short ? '0 : BIT_IDX_W'(1);
            PH_EXT:   units = r_short ? '0 : BIT_IDX_W'(EXT_BITS);
            PH_GUARD: units = BIT_IDX_W'(GUARD_ZEROS);
            default:  units = '0;
        endcase

        unique case (r_phase)
            PH_SMARK: level = 1'b1;
            PH_DATA, PH_TRAIL, PH_EXT, PH_GUARD: level = (r_slot == '0);
            default:  level = 1'b0;
        endcase

        unique case (r_phase)
            PH_IDLE:   succ = PH_IDLE;
            PH_SMARK:  succ = PH_SSPACE;
            PH_SSPACE: succ = PH_DATA;
            PH_DATA:   succ = PH_TRAIL;
            PH_TRAIL:  succ = PH_GAP;
            PH_GAP:    succ = PH_EXT;
            PH_EXT:    succ = PH_GUARD;
            PH_GUARD:  succ = PH_IDLE;
            default:   succ = PH_IDLE;
        endcase

        slot_inc = r_slot + SLOT_W'(1);
        bit_inc  = r_bit + BIT_IDX_W'(1);
        adv      = (slot_inc >= unit_len) || (slot_inc == '0);
    end

    // Next state and result
    always_comb begin
        n_phase     = r_phase;
        n_slot      = r_slot;
        n_bit       = r_bit;
        n_data      = r_data;
        n_ext       = r_ext;
        n_short     = r_short;
        n_carrier   = r_carrier;
        n_busy      = r_busy;
        n_last      = r_last;
        is_tick     = 1'b0;

        if (in_acc) begin
            unique case (i_in.cmd)
                CMD_TICK: begin
                    is_tick = 1'b1;
                    if (r_phase != PH_IDLE) begin
                        if (adv) begin
                            n_slot = '0;
                            if (bit_inc >= units) begin
                                n_bit   = '0;
                                n_phase = f_enter(succ, r_short,
                                    (r_short ? r_short_start_mark : r_start_mark) == '0,
                                    (r_short ? r_short_start_space : r_start_space) == '0,
                                    r_gap == '0);
                            end else begin
                                n_bit = bit_inc;
                            end
                        end else begin
                            n_slot = slot_inc;
                        end
                    end
                    n_carrier = level;
                    n_busy    = (r_phase != PH_IDLE);
                    n_last    = (r_phase != PH_IDLE) && (n_phase == PH_IDLE);
                end
                CMD_LONG, CMD_SHORT: begin
                    n_short = (i_in.cmd == CMD_SHORT);
                    if (n_short) begin
                        n_data = SHIFT_W'(i_in.short_word);
                        n_ext  = '0;
                    end else begin
                        n_data = SHIFT_W'(i_in.main_word);
                        n_ext  = SHIFT_W'(i_in.ext_word);
                    end
                    n_slot  = '0;
                    n_bit   = '0;
                    n_phase = f_enter(PH_SMARK, n_short,
                        (n_short ? r_short_start_mark : r_start_mark) == '0,
                        (n_short ? r_short_start_space : r_start_space) == '0,
                        r_gap == '0);
                end
                default: ;
            endcase
        end

        // hold a waiting result until the sink takes it
        if (in_acc) begin
            n_out_valid = is_tick;
        end else begin
            n_out_valid = r_out_valid && !o_out.ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_slot      <= '0;
            r_bit       <= '0;
            r_data      <= '0;
            r_ext       <= '0;
            r_short     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_slot      <= n_slot;
            r_bit       <= n_bit;
            r_data      <= n_data;
            r_ext       <= n_ext;
            r_short     <= n_short;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_carrier <= n_carrier;
        r_busy    <= n_busy;
        r_last    <= n_last;
    end

    // Idle encoder keeps its counters cleared
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> r_slot == '0 && r_bit == '0)
        else $error("counters not cleared while idle");

    // A send always lands in a phase that has slots to emit
    a_send_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_in.cmd == CMD_LONG || i_in.cmd == CMD_SHORT) |=> r_phase != PH_IDLE)
        else $error("send left the encoder idle");

    // A tick while idle returns an idle slot
    a_idle_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in.cmd == CMD_TICK && r_phase == PH_IDLE
        |=> r_out_valid && !r_busy && !r_carrier && !r_last)
        else $error("idle tick gave a frame slot");

    // Carrier and frame end only inside a frame
    a_frame_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_carrier || r_last) |-> r_busy)
        else $error("carrier or last outside a frame");

    // Frame end leaves the encoder idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in.cmd == CMD_TICK |=> !r_last || r_phase == PH_IDLE)
        else $error("last slot but frame still running");

endmodule

[tb/tb_ir_pulse_distance_frame_encoder_unit.sv]
// ----------------------------------------------------------------------------
// tb_ir_pulse_distance_frame_encoder_unit
// Self-checking bench for the IR pulse-distance frame encoder. Long and
// short frames with random payloads are started, cut short by restarts and
// clocked out slot by slot under random source gaps and sink stalls. Each
// slot level is checked against a bench-side frame sequencer. Register
// settings change between stimulus blocks, sometimes in the middle of a frame.
// ----------------------------------------------------------------------------
module tb_ir_pulse_distance_frame_encoder_unit;
    import irpd_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int N_BLOCKS       = 12;
    localparam int BLOCK_ITEMS    = 152;
    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 30;

    typedef struct packed {
        logic [CMD_W-1:0]      cmd;
        logic [MAIN_BITS-1:0]  main_word;
        logic [EXT_BITS-1:0]   ext_word;
        logic [SHORT_BITS-1:0] short_word;
    } t_ir_cmd;

    typedef struct packed {
        logic carrier;
        logic busy;
        logic end_of_frame;
    } t_slot;

    logic i_clk;
    logic i_rst_n;

    irpd_in_if  in_ch ();
    irpd_out_if out_ch ();
    irpd_cfg_if cfg_ch ();

    ir_pulse_distance_frame_encoder_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    t_ir_cmd cmd_q [$];
    t_slot   exp_slots [$];
    int      n_queued;
    int      n_accepted;
    int      n_results;
    int      n_err;
    int      n_gen;
    int      src_gap;
    int      sink_stall;
    int      idle_cycles;
    bit      calm;
    int      gen_reg [8];

    // Sequencer state for the expected slot levels
    t_phase                 ph;
    logic [SLOT_W-1:0]      slot_cnt;
    logic [BIT_IDX_W-1:0]   bit_idx;
    logic [SHIFT_W-1:0]     data_sh;
    logic [SHIFT_W-1:0]     ext_sh;
    logic                   short_md;
    logic [CFG_DATA_W-1:0]  seq_reg [8];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [CFG_DATA_W-1:0] reg_mask(input t_cfg_idx idx);
        case (idx)
            REG_ONE_SPACE, REG_ZERO_SPACE: return 8'h07;
            REG_TRAILER:                   return 8'hFF;
            default:                       return 8'h3F;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        else if (r < 95) return $urandom_range(3, 8);
        else return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Frame sequencer
    // ------------------------------------------------------------------
    function automatic int seg_units(input t_phase p);
        case (p)
            PH_SMARK, PH_SSPACE: return 1;
            PH_DATA:             return short_md ? SHORT_BITS : MAIN_BITS;
            PH_TRAIL:            return TRAILER_BITS;
            PH_GAP:              return short_md ? 0 : 1;
            PH_EXT:              return short_md ? 0 : EXT_BITS;
            PH_GUARD:            return GUARD_ZEROS;
            default:             return 0;
        endcase
    endfunction

    function automatic logic cur_bit();
        case (ph)
            PH_DATA:  return data_sh[bit_idx[SHIFT_IDX_W-1:0]];
            PH_TRAIL: return seq_reg[REG_TRAILER][bit_idx[TRAIL_IDX_W-1:0]];
            PH_EXT:   return ext_sh[bit_idx[SHIFT_IDX_W-1:0]];
            default:  return 1'b0;
        endcase
    endfunction

    function automatic int seg_len();
        case (ph)
            PH_SMARK:
                return short_md ? seq_reg[REG_SHORT_START_MARK] : seq_reg[REG_START_MARK];
            PH_SSPACE:
                return short_md ? seq_reg[REG_SHORT_START_SPACE] : seq_reg[REG_START_SPACE];
            PH_GAP:
                return seq_reg[REG_GAP];
            PH_DATA, PH_TRAIL, PH_EXT, PH_GUARD:
                return 1 + (cur_bit() ? seq_reg[REG_ONE_SPACE] : seq_reg[REG_ZERO_SPACE]);
            default:
                return 0;
        endcase
    endfunction

    // Drop finished segments and zero-length units until a slot is due.
    function automatic void skip_empty();
        bit done;
        done = 1'b0;
        while (ph != PH_IDLE && !done) begin
            if (int'(bit_idx) >= seg_units(ph)) begin
                ph       = (ph == PH_GUARD) ? PH_IDLE : t_phase'(int'(ph) + 1);
                bit_idx  = '0;
                slot_cnt = '0;
            end else if (seg_len() == 0) begin
                bit_idx  = bit_idx + 1'b1;
                slot_cnt = '0;
            end else begin
                done = 1'b1;
            end
        end
    endfunction

    function automatic void encode_step(input t_ir_cmd it, output bit has_slot,
                                        output t_slot s);
        logic lvl;
        has_slot = 1'b0;
        s        = '0;
        if (it.cmd == CMD_LONG || it.cmd == CMD_SHORT) begin
            short_md = (it.cmd == CMD_SHORT);
            if (short_md) begin
                data_sh = {{(SHIFT_W-SHORT_BITS){1'b0}}, it.short_word};
                ext_sh  = '0;
            end else begin
                data_sh = {{(SHIFT_W-MAIN_BITS){1'b0}}, it.main_word};
                ext_sh  = it.ext_word;
            end
            ph       = PH_SMARK;
            slot_cnt = '0;
            bit_idx  = '0;
            skip_empty();
        end else if (it.cmd == CMD_TICK) begin
            has_slot = 1'b1;
            if (ph != PH_IDLE) begin
                case (ph)
                    PH_SMARK:                            lvl = 1'b1;
                    PH_DATA, PH_TRAIL, PH_EXT, PH_GUARD: lvl = (slot_cnt == '0);
                    default:                             lvl = 1'b0;
                endcase
                slot_cnt = slot_cnt + 1'b1;
                if (int'(slot_cnt) >= seg_len() || slot_cnt == '0) begin
                    slot_cnt = '0;
                    bit_idx  = bit_idx + 1'b1;
                end
                skip_empty();
                s.carrier      = lvl;
                s.busy         = 1'b1;
                s.end_of_frame = (ph == PH_IDLE);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_item(input logic [CMD_W-1:0] c, input logic [MAIN_BITS-1:0] mw,
                              input logic [EXT_BITS-1:0] ew,
                              input logic [SHORT_BITS-1:0] sw);
        t_ir_cmd it;
        it.cmd        = c;
        it.main_word  = mw;
        it.ext_word   = ew;
        it.short_word = sw;
        cmd_q.push_back(it);
        n_queued++;
        if (c != CMD_UNUSED) n_gen++;
    endtask

    task automatic queue_rand(input logic [CMD_W-1:0] c);
        logic [31:0] mw, ew, sw;
        mw = $urandom;
        ew = $urandom;
        sw = $urandom;
        queue_item(c, mw[MAIN_BITS-1:0], ew, sw[SHORT_BITS-1:0]);
    endtask

    function automatic logic [31:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        else if (r == 1) return '1;
        else if (r == 2) return 32'd1 << $urandom_range(0, 31);
        else return $urandom;
    endfunction

    function automatic int bit_slots(input logic [31:0] w, input int n);
        int sum;
        sum = 0;
        for (int i = 0; i < n; i++)
            sum += 1 + (w[i] ? gen_reg[REG_ONE_SPACE] : gen_reg[REG_ZERO_SPACE]);
        return sum;
    endfunction

    // Send command, then enough ticks to finish the frame, or fewer when a
    // restart is meant to cut it short or the block has no room left.
    task automatic queue_frame(input bit short_f, input bit cut, input int budget);
        logic [31:0] mw, ew, sw;
        int len;
        mw = pick_word();
        ew = pick_word();
        sw = pick_word();
        queue_item(short_f ? CMD_SHORT : CMD_LONG, mw[MAIN_BITS-1:0], ew, sw[SHORT_BITS-1:0]);
        if (short_f)
            len = gen_reg[REG_SHORT_START_MARK] + gen_reg[REG_SHORT_START_SPACE]
                + bit_slots(sw, SHORT_BITS);
        else
            len = gen_reg[REG_START_MARK] + gen_reg[REG_START_SPACE]
                + bit_slots(mw, MAIN_BITS) + gen_reg[REG_GAP] + bit_slots(ew, EXT_BITS);
        len += bit_slots(gen_reg[REG_TRAILER], TRAILER_BITS) + bit_slots('0, GUARD_ZEROS);
        if (cut) len = $urandom_range(0, len - 1);
        else len += $urandom_range(0, 3);
        if (len > budget) len = budget;
        repeat (len) queue_rand(CMD_TICK);
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (n_accepted != n_queued || exp_slots.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int val);
        gen_reg[idx] = val & reg_mask(idx);
        cfg_ch.valid <= 1'b1;
        cfg_ch.idx   <= idx;
        cfg_ch.wdata <= val[CFG_DATA_W-1:0];
        do @(posedge i_clk);
        while (!cfg_ch.ready);
    endtask

    // Block 1 gap and trailer zero and the rest one, 2 all maximum, 3 zero-length segments, then random.
    task automatic program_setting(input int blk);
        t_cfg_idx r;
        int v;
        for (int k = 0; k < 8; k++) begin
            r = t_cfg_idx'(k);
            case (blk)
                1: v = (r == REG_GAP || r == REG_TRAILER) ? 0 : 1;
                2: v = (r == REG_ONE_SPACE || r == REG_ZERO_SPACE) ? 7
                     : (r == REG_TRAILER) ? 255 : 63;
                3: v = (r == REG_TRAILER) ? 8'h5A : 0;
                default: v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                         : $urandom_range(0, 6);
            endcase
            if (blk <= 3 || $urandom_range(0, 99) < 60) write_reg(r, v);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (n_err < MAX_REPORTS)
            $display("mismatch at slot %0d: %s got %0d want %0d", n_results, what, got, want);
        n_err++;
    endtask

    // ------------------------------------------------------------------
    // Command driver
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_ir_cmd it;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            src_gap = 0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (src_gap > 0) begin
                src_gap--;
                in_ch.valid <= 1'b0;
            end else if (cmd_q.size() > 0) begin
                it = cmd_q.pop_front();
                in_ch.valid      <= 1'b1;
                in_ch.cmd        <= it.cmd;
                in_ch.main_word  <= it.main_word;
                in_ch.ext_word   <= it.ext_word;
                in_ch.short_word <= it.short_word;
                if (!calm && $urandom_range(0, 99) < 25) src_gap = pick_gap();
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Result sink with random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            sink_stall = 0;
        end else if (sink_stall > 0) begin
            sink_stall--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
            if (!calm && $urandom_range(0, 99) < 20) sink_stall = pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // Monitor: register writes, command transfers, result checks
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_ir_cmd it;
        t_slot   s;
        t_slot   want;
        bit      has_slot;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (exp_slots.size() == 0) begin
                    report_mismatch("result with nothing pending, carrier", out_ch.carrier_on, 0);
                end else begin
                    want = exp_slots.pop_front();
                    if (out_ch.carrier_on !== want.carrier)
                        report_mismatch("carrier_on", out_ch.carrier_on, want.carrier);
                    if (out_ch.busy_res !== want.busy)
                        report_mismatch("busy_res", out_ch.busy_res, want.busy);
                    if (out_ch.last !== want.end_of_frame)
                        report_mismatch("last", out_ch.last, want.end_of_frame);
                end
                n_results++;
            end
            if (in_ch.valid && in_ch.ready) begin
                it.cmd        = in_ch.cmd;
                it.main_word  = in_ch.main_word;
                it.ext_word   = in_ch.ext_word;
                it.short_word = in_ch.short_word;
                encode_step(it, has_slot, s);
                if (has_slot) exp_slots.push_back(s);
                n_accepted++;
            end
            if (cfg_ch.valid && cfg_ch.ready)
                seq_reg[cfg_ch.idx] = cfg_ch.wdata & reg_mask(t_cfg_idx'(cfg_ch.idx));
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("** ir_pulse_distance_frame_encoder_unit: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int blk;
        int block_start;
        int r;
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.cmd        = CMD_TICK;
        in_ch.main_word  = '0;
        in_ch.ext_word   = '0;
        in_ch.short_word = '0;
        out_ch.ready     = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.idx       = REG_START_MARK;
        cfg_ch.wdata     = '0;
        calm        = 1'b0;
        n_queued    = 0;
        n_accepted  = 0;
        n_results   = 0;
        n_err       = 0;
        n_gen       = 0;
        idle_cycles = 0;
        gen_reg = '{RST_START_MARK, RST_START_SPACE, RST_SHORT_START_MARK,
                    RST_SHORT_START_SPACE, RST_GAP, RST_ONE_SPACE, RST_ZERO_SPACE,
                    RST_TRAILER};
        seq_reg = '{RST_START_MARK, RST_START_SPACE, RST_SHORT_START_MARK,
                    RST_SHORT_START_SPACE, RST_GAP, RST_ONE_SPACE, RST_ZERO_SPACE,
                    RST_TRAILER};
        ph       = PH_IDLE;
        slot_cnt = '0;
        bit_idx  = '0;
        data_sh  = '0;
        ext_sh   = '0;
        short_md = 1'b0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: idle ticks, unused code, restarts of both frame kinds
        queue_item(CMD_TICK, '0, '0, '0);
        queue_item(CMD_UNUSED, '1, '1, '1);
        queue_item(CMD_TICK, '1, '1, '1);
        queue_item(CMD_LONG, '1, '1, '0);
        repeat (4) queue_item(CMD_TICK, '0, '0, '0);
        queue_item(CMD_LONG, '0, '0, '1);
        repeat (3) queue_item(CMD_TICK, '0, '0, '0);
        queue_item(CMD_SHORT, '0, '0, 8'hFF);
        repeat (3) queue_item(CMD_TICK, '0, '0, '0);
        queue_item(CMD_SHORT, '1, '1, 8'h00);
        queue_item(CMD_UNUSED, '0, '0, '0);
        repeat (2) queue_item(CMD_TICK, '0, '0, '0);

        for (blk = 0; blk < N_BLOCKS; blk++) begin
            // Hold off the sender until every pending slot has come back
            if (blk > 0) begin
                wait_drained();
                program_setting(blk);
            end
            calm = (blk % 4 == 3);
            block_start = n_gen;
            repeat ($urandom_range(0, 20)) queue_rand(CMD_TICK);
            while (n_gen - block_start < BLOCK_ITEMS) begin
                r = $urandom_range(0, 99);
                if (r < 3) queue_rand(CMD_UNUSED);
                else if (r < 8) queue_rand(CMD_TICK);
                else if (r < 12) queue_rand(($urandom_range(0, 1) == 1) ? CMD_LONG : CMD_SHORT);
                else queue_frame($urandom_range(0, 1), $urandom_range(0, 4) == 0,
                                 BLOCK_ITEMS - (n_gen - block_start) - 1);
            end
        end

        wait_drained();
        if (n_err == 0)
            $display("** ir_pulse_distance_frame_encoder_unit: PASSED **");
        else
            $display("** ir_pulse_distance_frame_encoder_unit: FAILED **");
        $finish;
    end

endmodule

[ir_pulse_distance_frame_encoder_unit.f]
design/irpd_pkg.sv
design/irpd_if.sv
design/ir_pulse_distance_frame_encoder_unit.sv
tb/tb_ir_pulse_distance_frame_encoder_unit.sv
